// ----- hw/rtl/text_console_writer_with_scroll_top_macros.svh -----
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_WITH_SCROLL_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_WITH_SCROLL_TOP_MACROS_SVH

// The property must hold in the same cycle as its trigger.
`define TCW_ASSERT_NOW(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// The property must hold in the cycle after its trigger.
`define TCW_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// ----- hw/rtl/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
package tcw_pkg;

	// Default screen geometry.
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF = 25;
	localparam int SCREENS_DEF = 2;

	// Widest screen select that the screen count allows.
	localparam int MAX_SCREEN_W = 3;

	// Entries of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	// Byte that blanks a cell.
	localparam logic [7:0] BLANK = 8'h20;

	// Command codes, encoded as on the action field.
	typedef enum logic [1:0] {
		OP_PUT     = 2'd0,
		OP_NEWLINE = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	// One classified command.
	typedef struct packed {
		op_t                     op;
		logic [MAX_SCREEN_W-1:0] screen;
		logic [7:0]              char_code;
		logic                    text_start;
		logic                    read_ok;
		logic [10:0]             cell_index;
	} cmd_t;

	// A command together with its valid flag.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_beat_t;

endpackage

// ----- hw/rtl/tcw_front.sv -----
// Front end: accepts input beats and classifies them into commands.
module tcw_front #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int SCREENS = tcw_pkg::SCREENS_DEF
) (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic              screen,
	input  logic [7:0]        char_code,
	input  logic              text_start,
	input  logic [10:0]       cell_index,
	input  logic              q_full,
	output tcw_pkg::cmd_beat_t push
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;

	// The queue absorbs a beat whenever it has room.
	assign in_stall = q_full;

	// Fold the screen number onto the existing buffers and check the read range.
	always_comb begin
		push.valid = in_valid;
		push.cmd.op = op_t'(action);
		push.cmd.screen = (SCREENS == 1) ? '0 : MAX_SCREEN_W'(screen);
		push.cmd.char_code = char_code;
		push.cmd.text_start = text_start;
		push.cmd.read_ok = (32'(cell_index) < 32'(CELLS));
		push.cmd.cell_index = cell_index;
	end

endmodule

// ----- hw/rtl/tcw_queue.sv -----
// Short command queue that decouples the front end from the executing back end.
`include "text_console_writer_with_scroll_top_macros.svh"

module tcw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::cmd_beat_t push,
	output logic               full,
	output tcw_pkg::cmd_beat_t head,
	input  logic               pop
);
	import tcw_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CNTW-1:0] count_q;
	logic            push_acc;

	assign full = (count_q == CNTW'(QUEUE_DEPTH));
	assign push_acc = push.valid && !full;
	assign head.valid = (count_q != '0);
	assign head.cmd = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_acc) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_acc && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_acc) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push_acc) begin
			entry_q[wr_ptr_q] <= push.cmd;
		end
	end

	`TCW_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNTW'(QUEUE_DEPTH), "queue count overflow")
	`TCW_ASSERT_NEXT(a_push_grows, push_acc && !pop, count_q == $past(count_q) + 1'b1, "push lost")
	`TCW_ASSERT_NEXT(a_pop_shrinks, pop && !push_acc, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

// ----- hw/rtl/tcw_back.sv -----
// Back end: cursor registers, cell memory and the sequencer that runs each command.
`include "text_console_writer_with_scroll_top_macros.svh"

module tcw_back #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int SCREENS = tcw_pkg::SCREENS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::cmd_beat_t head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         read_char,
	output logic [10:0]        cursor_pos,
	output logic               scrolled
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int SW = (SCREENS > 1) ? $clog2(SCREENS) : 1;
	localparam int CELLW = $clog2(CELLS);
	localparam int CURW = $clog2(CELLS + 1);
	localparam int RW = $clog2(ROWS + 1);
	localparam int COLW = $clog2(COLUMNS);
	localparam int AW = SW + CELLW;
	localparam int DEPTH = 2 ** AW;
	localparam logic [CELLW-1:0] LAST_CELL = CELLW'(CELLS - 1);
	localparam logic [CELLW-1:0] SHIFT_END = CELLW'(CELLS - COLUMNS);

	// Sequencer states.
	localparam logic [2:0] ST_INIT = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_BLANK = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_PUT = 3'd5;
	localparam logic [2:0] ST_RESULT = 3'd6;

	logic [2:0]       state_q;
	cmd_t             cmd_q;
	logic             scr_q;
	logic [AW-1:0]    init_cnt_q;
	logic [CELLW-1:0] cnt_q;
	logic             shift_wv_s1;
	logic [CELLW-1:0] shift_wa_s1;
	logic [RW-1:0]    row_q [SCREENS];
	logic [COLW-1:0]  col_q [SCREENS];
	logic [7:0]       cell_mem_q [DEPTH];
	logic [7:0]       rdata_q;
	logic             out_valid_q;
	logic [7:0]       read_char_q;
	logic [10:0]      cursor_pos_q;
	logic             scrolled_q;

	logic [SW-1:0]    s;
	logic [RW-1:0]    cur_row;
	logic [COLW-1:0]  cur_col;
	logic [CURW-1:0]  cur_lin;
	logic             need_scroll;
	logic             start_blank;
	logic             out_free;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [7:0]       mem_wd;
	logic             mem_re;
	logic [AW-1:0]    mem_ra;

	// Cursor of the screen that the current command addresses.
	assign s = cmd_q.screen[SW-1:0];
	assign cur_row = row_q[s];
	assign cur_col = col_q[s];
	assign cur_lin = CURW'(32'(cur_row) * COLUMNS + 32'(cur_col));
	assign need_scroll = (cur_row == RW'(ROWS)) ||
		((cur_row == RW'(ROWS - 1)) && (cur_col == COLW'(COLUMNS - 1)));
	assign start_blank = cmd_q.text_start && (cur_row == '0) && (cur_col == '0);
	assign out_free = !out_valid_q || !out_stall;
	assign pop = (state_q == ST_IDLE) && head.valid;

	// Memory port selection.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = {s, cnt_q};
		mem_wd = BLANK;
		mem_re = 1'b0;
		mem_ra = {s, CELLW'(cmd_q.cell_index)};
		case (state_q)
			ST_INIT: begin
				mem_we = 1'b1;
				mem_wa = init_cnt_q;
			end
			ST_BLANK: begin
				mem_we = 1'b1;
			end
			ST_SHIFT: begin
				mem_we = shift_wv_s1;
				mem_wa = {s, shift_wa_s1};
				mem_wd = rdata_q;
				mem_re = (cnt_q < SHIFT_END);
				mem_ra = {s, CELLW'(32'(cnt_q) + COLUMNS)};
			end
			ST_PUT: begin
				mem_we = 1'b1;
				mem_wa = {s, CELLW'(cur_lin)};
				mem_wd = cmd_q.char_code;
			end
			ST_EXEC: begin
				mem_re = (cmd_q.op == OP_READ);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Cell memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem_q[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rdata_q <= cell_mem_q[mem_ra];
		end
	end

	// Write strobe of the shift sweep, set in the cycle after its read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_wv_s1 <= 1'b0;
		end else begin
			shift_wv_s1 <= (state_q == ST_SHIFT) && (cnt_q != SHIFT_END);
		end
	end

	// Result valid: set when a result is issued, cleared once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer and cursors.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cmd_q <= '0;
			scr_q <= 1'b0;
			init_cnt_q <= '0;
			cnt_q <= '0;
			shift_wa_s1 <= '0;
			for (int i = 0; i < SCREENS; i++) begin
				row_q[i] <= '0;
				col_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_INIT: begin
					init_cnt_q <= init_cnt_q + 1'b1;
					if (init_cnt_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						cmd_q <= head.cmd;
						scr_q <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cnt_q <= '0;
					case (cmd_q.op)
						OP_PUT: begin
							if (start_blank) begin
								state_q <= ST_BLANK;
							end else if (need_scroll) begin
								row_q[s] <= cur_row - 1'b1;
								scr_q <= 1'b1;
								state_q <= ST_SHIFT;
							end else begin
								state_q <= ST_PUT;
							end
						end
						OP_NEWLINE: begin
							if (cur_row != RW'(ROWS)) begin
								row_q[s] <= cur_row + 1'b1;
							end
							col_q[s] <= '0;
							state_q <= ST_RESULT;
						end
						OP_CLEAR: begin
							row_q[s] <= '0;
							col_q[s] <= '0;
							state_q <= ST_BLANK;
						end
						default: begin
							state_q <= ST_RESULT;
						end
					endcase
				end
				ST_BLANK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_CELL) begin
						state_q <= (cmd_q.op == OP_PUT) ? ST_PUT : ST_RESULT;
					end
				end
				ST_SHIFT: begin
					// Read one row ahead, write the cell back in the cycle after.
					shift_wa_s1 <= cnt_q;
					if (cnt_q == SHIFT_END) begin
						state_q <= ST_BLANK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PUT: begin
					if (cur_col == COLW'(COLUMNS - 1)) begin
						col_q[s] <= '0;
						row_q[s] <= cur_row + 1'b1;
					end else begin
						col_q[s] <= cur_col + 1'b1;
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			read_char_q <= ((cmd_q.op == OP_READ) && cmd_q.read_ok) ? rdata_q : 8'd0;
			cursor_pos_q <= 11'(cur_lin);
			scrolled_q <= scr_q;
		end
	end

	assign out_valid = out_valid_q;
	assign read_char = read_char_q;
	assign cursor_pos = cursor_pos_q;
	assign scrolled = scrolled_q;

	`TCW_ASSERT_NOW(a_shift_wr_in_sweep, shift_wv_s1, state_q == ST_SHIFT, "shift write outside sweep")
	`TCW_ASSERT_NOW(a_cursor_limit, cur_row == RW'(ROWS), cur_col == '0, "cursor past screen end")
	`TCW_ASSERT_NOW(a_result_origin, $rose(out_valid_q), $past(state_q) == ST_RESULT, "stray result")
	`TCW_ASSERT_NEXT(a_init_once, state_q != ST_INIT, state_q != ST_INIT, "clearing pass repeated")

endmodule

// ----- hw/rtl/text_console_writer_with_scroll_top.sv -----
// Top level of the text console writer with one-row scroll.
//
// Input channel (in_valid, in_stall): each beat carries action, screen,
// char_code, text_start and cell_index. Output channel (out_valid,
// out_stall): exactly one result beat per input beat, in order, carrying
// read_char, cursor_pos and scrolled.
// A two-entry command queue sits between the front end and the executing
// back end, so input beats keep being taken while a result waits, until the queue is full.
// A command leaves the queue through the sequencer states IDLE and EXEC,
// then the states its op needs (BLANK, SHIFT, PUT), then RESULT, where its
// result beat is registered. The back end runs one command at a time through
// one memory write port and takes no new command until the last has issued
// its result. A clear blanks every cell of its screen; a scrolling put_char
// shifts the rows up, then blanks the last row. After reset the cell memory
// is filled with spaces, one byte a cycle over 2**(screen bits + cell bits)
// entries (4096 at 80x25, two screens); input beats queue up meanwhile and
// execute afterwards. While the receiver stalls, the result holds and the
// back end stops at its next result until the output register frees up.
module text_console_writer_with_scroll_top #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS = tcw_pkg::ROWS_DEF,
	parameter int SCREENS = tcw_pkg::SCREENS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic        screen,
	input  logic [7:0]  char_code,
	input  logic        text_start,
	input  logic [10:0] cell_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_char,
	output logic [10:0] cursor_pos,
	output logic        scrolled
);
	import tcw_pkg::*;

	cmd_beat_t push;
	cmd_beat_t head;
	logic      q_full;
	logic      pop;

	// Classify input beats.
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.SCREENS(SCREENS)
	) u_front (
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.screen(screen),
		.char_code(char_code),
		.text_start(text_start),
		.cell_index(cell_index),
		.q_full(q_full),
		.push(push)
	);

	// Buffer commands between the two halves.
	tcw_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(q_full),
		.head(head),
		.pop(pop)
	);

	// Execute commands against the cursors and cell memory.
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.SCREENS(SCREENS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_char(read_char),
		.cursor_pos(cursor_pos),
		.scrolled(scrolled)
	);

endmodule

// ----- tb/tb_text_console_writer_with_scroll_top.sv -----
// Self-checking testbench for the text console writer with one-row scroll.
module tb_text_console_writer_with_scroll_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int COLUMNS = COLUMNS_DEF;
	localparam int ROWS = ROWS_DEF;
	localparam int SCREENS = SCREENS_DEF;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int RANDOM_BEATS = 1750;
	localparam int QUIET_BEATS = 250;
	// Far beyond a run where every beat clears or scrolls a whole screen.
	localparam int CYCLE_LIMIT = 12_000_000;

	// One console command as driven on the input ports.
	typedef struct {
		op_t        op;
		bit         scr;
		bit [7:0]   ch;
		bit         start;
		bit [10:0]  idx;
	} console_cmd_t;

	// One result beat as seen on the output ports.
	typedef struct {
		bit [7:0]   rd;
		bit [10:0]  cur;
		bit         scrolled;
	} console_result_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic        screen;
	logic [7:0]  char_code;
	logic        text_start;
	logic [10:0] cell_index;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  read_char;
	logic [10:0] cursor_pos;
	logic        scrolled;

	// Shadow copy of the screens and cursors.
	logic [7:0] screen_cells [SCREENS][CELLS];
	int unsigned cursors [SCREENS];

	console_result_t pending_results [$];
	console_result_t expected_beat;
	int fail_count = 0;
	int beats_sent = 0;
	int stall_left = 0;
	bit quiet = 1'b0;

	text_console_writer_with_scroll_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.screen(screen),
		.char_code(char_code),
		.text_start(text_start),
		.cell_index(cell_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_char(read_char),
		.cursor_pos(cursor_pos),
		.scrolled(scrolled)
	);

	// Free-running clock, 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run is abandoned if it goes on far longer than any correct run could.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_text_console_writer_with_scroll_top NOT OK");
		$finish;
	end

	// Receiver stalls in random bursts, and not at all once the run goes quiet.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (quiet) begin
				out_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				out_stall = ($urandom_range(0, 2) == 0);
				stall_left = $urandom_range(1, 17) - 1;
			end
		end
	end

	// Every accepted result beat is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no prediction waiting: cursor_pos %0d", cursor_pos);
				fail_count++;
			end else begin
				expected_beat = pending_results.pop_front();
				if (read_char !== expected_beat.rd) begin
					$error("read_char: expected %0d, got %0d", expected_beat.rd, read_char);
					fail_count++;
				end
				if (cursor_pos !== expected_beat.cur) begin
					$error("cursor_pos: expected %0d, got %0d", expected_beat.cur, cursor_pos);
					fail_count++;
				end
				if (scrolled !== expected_beat.scrolled) begin
					$error("scrolled: expected %0d, got %0d", expected_beat.scrolled, scrolled);
					fail_count++;
				end
			end
		end
	end

	// Fill a screen with spaces and home its cursor.
	function automatic void blank_screen(int s);
		for (int i = 0; i < CELLS; i++) screen_cells[s][i] = BLANK;
		cursors[s] = 0;
	endfunction

	// Apply one command to the shadow screens and return the result it yields.
	function automatic console_result_t console_apply(console_cmd_t c);
		console_result_t r;
		int s;
		int unsigned next_row;
		r = '{default: 0};
		s = int'(c.scr) % SCREENS;
		case (c.op)
			OP_PUT: begin
				if (c.start && cursors[s] == 0) blank_screen(s);
				// Scroll one row up once the cursor reaches the last cell.
				if (cursors[s] + 1 >= CELLS) begin
					for (int i = 0; i < CELLS - COLUMNS; i++)
						screen_cells[s][i] = screen_cells[s][i + COLUMNS];
					for (int i = CELLS - COLUMNS; i < CELLS; i++)
						screen_cells[s][i] = BLANK;
					cursors[s] = (cursors[s] >= COLUMNS) ? cursors[s] - COLUMNS : 0;
					r.scrolled = 1'b1;
				end
				if (cursors[s] < CELLS) begin
					screen_cells[s][cursors[s]] = c.ch;
					cursors[s]++;
				end
			end
			OP_NEWLINE: begin
				next_row = (cursors[s] / COLUMNS + 1) * COLUMNS;
				cursors[s] = (next_row > CELLS) ? CELLS : next_row;
			end
			OP_CLEAR: begin
				blank_screen(s);
			end
			default: begin
				if (c.idx < CELLS) r.rd = screen_cells[s][c.idx];
			end
		endcase
		r.cur = cursors[s][10:0];
		return r;
	endfunction

	function automatic console_cmd_t make_cmd(op_t op, bit scr, bit [7:0] ch, bit start,
			bit [10:0] idx);
		console_cmd_t c;
		c.op = op;
		c.scr = scr;
		c.ch = ch;
		c.start = start;
		c.idx = idx;
		return c;
	endfunction

	// Drive one beat from a falling edge, hold it until taken, record the prediction.
	task automatic send_beat(console_cmd_t c);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = c.op;
		screen = c.scr;
		char_code = c.ch;
		text_start = c.start;
		cell_index = c.idx;
		do @(posedge clk); while (in_stall);
		pending_results.push_back(console_apply(c));
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic put_char(bit scr, bit [7:0] ch, bit start);
		send_beat(make_cmd(OP_PUT, scr, ch, start, 11'($urandom_range(0, 2047))));
	endtask

	task automatic read_cell(bit scr, int idx);
		send_beat(make_cmd(OP_READ, scr, 8'($urandom), 1'($urandom), 11'(idx)));
	endtask

	task automatic newline(bit scr);
		send_beat(make_cmd(OP_NEWLINE, scr, 8'($urandom), 1'($urandom),
			11'($urandom_range(0, 2047))));
	endtask

	task automatic clear_screen(bit scr);
		send_beat(make_cmd(OP_CLEAR, scr, 8'($urandom), 1'($urandom),
			11'($urandom_range(0, 2047))));
	endtask

	// Extreme bytes, the text-start clear and its absence away from home.
	task automatic test_put_extremes();
		put_char(1'b0, 8'h00, 1'b1);
		put_char(1'b0, 8'hFF, 1'b0);
		put_char(1'b0, 8'h41, 1'b1);
		put_char(1'b1, 8'h7E, 1'b0);
		read_cell(1'b0, 0);
		read_cell(1'b0, 1);
		read_cell(1'b0, 2);
		read_cell(1'b1, 0);
	endtask

	// Newline, clear, and reads at the edges of the screen and beyond it.
	task automatic test_newline_clear_read();
		newline(1'b0);
		put_char(1'b0, 8'h5A, 1'b0);
		read_cell(1'b0, COLUMNS);
		read_cell(1'b0, CELLS - 1);
		read_cell(1'b0, CELLS);
		read_cell(1'b0, 2047);
		clear_screen(1'b0);
		read_cell(1'b0, 1);
	endtask

	// Newlines pin the cursor one past the last cell; the next byte scrolls.
	task automatic test_last_row();
		while (cursors[1] < CELLS) newline(1'b1);
		newline(1'b1);
		put_char(1'b1, 8'hA5, 1'b0);
		read_cell(1'b1, CELLS - COLUMNS);
		read_cell(1'b1, CELLS - COLUMNS - 1);
	endtask

	// Random sequences, mostly well-formed text with some noise mixed in.
	task automatic test_random_traffic(int beats);
		int stop_at;
		int kind;
		int n;
		bit s;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			kind = $urandom_range(0, 9);
			s = 1'($urandom);
			case (kind)
				0, 1: begin
					send_beat(make_cmd(op_t'($urandom_range(0, 3)), s, 8'($urandom),
						1'($urandom), 11'($urandom_range(0, 2047))));
				end
				2, 3, 4, 5: begin
					// A line of text with the odd newline inside it.
					n = $urandom_range(1, 60);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 9) == 0) newline(s);
						else put_char(s, 8'($urandom), (i == 0) && $urandom_range(0, 1));
					end
					repeat ($urandom_range(1, 3))
						read_cell(s, (cursors[s] > 0) ? $urandom_range(0, cursors[s] - 1) : 0);
				end
				6: begin
					// Run down to the last row and type a run of bytes that often goes past the end of the screen.
					while (cursors[s] / COLUMNS < ROWS - 1) newline(s);
					repeat ($urandom_range(70, 100)) put_char(s, 8'($urandom), 1'b0);
					repeat (3) read_cell(s, $urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
				end
				7: begin
					// Park the cursor past the last cell, then write.
					while (cursors[s] < CELLS) newline(s);
					if ($urandom_range(0, 1)) newline(s);
					repeat ($urandom_range(1, 5)) put_char(s, 8'($urandom), 1'($urandom));
					read_cell(s, $urandom_range(CELLS - COLUMNS, CELLS - 1));
				end
				8: begin
					repeat (4) begin
						if ($urandom_range(0, 7) == 0) read_cell(s, $urandom_range(CELLS, 2047));
						else read_cell(s, $urandom_range(0, CELLS - 1));
					end
				end
				default: begin
					if ($urandom_range(0, 2) == 0) clear_screen(s);
					put_char(s, 8'($urandom), 1'($urandom));
				end
			endcase
		end
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = OP_PUT;
		screen = 1'b0;
		char_code = 8'h00;
		text_start = 1'b0;
		cell_index = 11'd0;
		for (int s = 0; s < SCREENS; s++) blank_screen(s);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_put_extremes();
		test_newline_clear_read();
		test_last_row();
		test_random_traffic(RANDOM_BEATS);
		quiet = 1'b1;
		test_random_traffic(QUIET_BEATS);
		in_valid = 1'b0;

		// Drain outstanding results, then watch for strays.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_text_console_writer_with_scroll_top OK");
		end else begin
			$display("tb_text_console_writer_with_scroll_top NOT OK");
		end
		$finish;
	end

endmodule

// ----- text_console_writer_with_scroll_top.f -----
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_queue.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_with_scroll_top.sv
tb/tb_text_console_writer_with_scroll_top.sv
